// ----- rtl/core/ofm_pkg.sv -----
// Shared types, constants and the gap-to-weight table of the overcurrent frequency monitor.
package ofm_pkg;

	// Field and state widths
	localparam int GAP_W    = 13;
	localparam int SUM_W    = 16;
	localparam int TOTAL_W  = 8;
	localparam int WLIM_W   = 7;
	localparam int WEIGHT_W = 7;
	localparam int FAULT_W  = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Default window length in ticks
	localparam int WINDOW_LEN_DEF = 100;

	// Saturation point of the gap counter
	localparam logic [GAP_W-1:0] GAP_CAP = 13'd6000;

	// Fault codes
	localparam logic [FAULT_W-1:0] FAULT_NONE   = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_WEIGHT = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_BURST  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT = 2'd2;

	// Reset values of the configuration registers
	localparam logic [SUM_W-1:0]   WEIGHT_LIMIT_RST = 16'd600;
	localparam logic [TOTAL_W-1:0] EVENT_LIMIT_RST  = 8'd10;
	localparam logic [WLIM_W-1:0]  WINDOW_LIMIT_RST = 7'd10;

	// Gap bounds (inclusive) and the weight for each step; the last weight covers long gaps
	localparam int NUM_BOUNDS = 14;
	localparam logic [GAP_W-1:0] GAP_BOUND [NUM_BOUNDS] = '{
		13'd2, 13'd5, 13'd8, 13'd13, 13'd20, 13'd30, 13'd40,
		13'd50, 13'd60, 13'd70, 13'd100, 13'd200, 13'd1000, 13'd4000
	};
	localparam logic [WEIGHT_W-1:0] GAP_WEIGHT [NUM_BOUNDS+1] = '{
		7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
		7'd65, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd0
	};

	// Control from the tick logic to the window chain
	typedef struct packed {
		logic adv;  // shift the window by one tick
		logic ev;   // event bit entering the window
	} win_ctl_t;

	// Map a gap to its weight: first bound that the gap does not exceed
	function automatic logic [WEIGHT_W-1:0] weight_of_gap(input logic [GAP_W-1:0] gap);
		logic [WEIGHT_W-1:0] w;
		w = GAP_WEIGHT[NUM_BOUNDS];
		for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
			if (gap <= GAP_BOUND[i]) begin
				w = GAP_WEIGHT[i];
			end
		end
		return w;
	endfunction

endpackage

// ----- rtl/core/ofm_cell.sv -----
// One window cell: holds the event bit of one tick and passes it on when the window advances.
module ofm_cell import ofm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic d,
	output logic q
);

	logic bit_q;

	// Load the neighbor's bit on each advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (adv) begin
			bit_q <= d;
		end
	end

	assign q = bit_q;

endmodule

// ----- rtl/core/ofm_window.sv -----
// Sliding event window: a row of cells plus the running count of events it holds.
module ofm_window import ofm_pkg::*; #(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	parameter int CNT_W      = $clog2(WINDOW_LEN + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  win_ctl_t         ctl,
	output logic [CNT_W-1:0] cnt,
	output logic [CNT_W-1:0] cnt_nxt
);

	logic [WINDOW_LEN-1:0] taps;
	logic [CNT_W-1:0]      cnt_q;

	// Chain of cells: cell 0 takes the new bit, the last cell holds the oldest tick
	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		if (i == 0) begin : g_head
			ofm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.adv    (ctl.adv),
				.d      (ctl.ev),
				.q      (taps[i])
			);
		end else begin : g_body
			ofm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.adv    (ctl.adv),
				.d      (taps[i-1]),
				.q      (taps[i])
			);
		end
	end

	// Add the entering bit, drop the bit that leaves the far end
	assign cnt_nxt = cnt_q + CNT_W'(ctl.ev) - CNT_W'(taps[WINDOW_LEN-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.adv) begin
			cnt_q <= cnt_nxt;
		end
	end

	assign cnt = cnt_q;

	// Count tracks the cells
	a_cnt_matches: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CNT_W'($countones(taps)))
		else $error("window count differs from cells");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WINDOW_LEN))
		else $error("window count above window length");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.adv |=> $stable(cnt_q))
		else $error("window count moved without advance");

endmodule

// ----- rtl/core/overcurrent_frequency_monitor.sv -----
// A result is registered in the output buffer when its tick transaction is accepted.
// Throughput: one tick per cycle; a two-entry output buffer keeps input stall
// registered, so ticks flow back to back unless two results wait downstream.
// Reset clears gap, sum, total, window cells and count, and sets the limits to
// 600, 10 and 10; no clearing pass is needed.
module overcurrent_frequency_monitor import ofm_pkg::*; #(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	parameter int CNT_W      = $clog2(WINDOW_LEN + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  overcurrent_event,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [FAULT_W-1:0]    fault,
	output logic [SUM_W-1:0]      weighted_total,
	output logic [CNT_W-1:0]      events_in_window,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CMP_W = (CNT_W > WLIM_W) ? CNT_W : WLIM_W;

	logic [SUM_W-1:0]   weight_limit_q;
	logic [TOTAL_W-1:0] event_limit_q;
	logic [WLIM_W-1:0]  window_limit_q;

	logic [GAP_W-1:0]   gap_q;
	logic [SUM_W-1:0]   sum_q;
	logic [TOTAL_W-1:0] total_q;

	logic               accept;
	logic               pop;
	logic [GAP_W-1:0]   gap_inc;
	logic [GAP_W-1:0]   gap_n;
	logic [WEIGHT_W-1:0] weight;
	logic [SUM_W:0]     sum_ext;
	logic [SUM_W-1:0]   sum_n;
	logic [TOTAL_W-1:0] total_n;
	logic               weight_fault;
	win_ctl_t           win_ctl;
	logic [CNT_W-1:0]   cnt;
	logic [CNT_W-1:0]   cnt_nxt;
	logic [CNT_W-1:0]   res_cnt;
	logic [FAULT_W-1:0] res_fault;

	logic               out_valid_q;
	logic [FAULT_W-1:0] out_fault_q;
	logic [SUM_W-1:0]   out_sum_q;
	logic [CNT_W-1:0]   out_cnt_q;
	logic               skid_valid_q;
	logic [FAULT_W-1:0] skid_fault_q;
	logic [SUM_W-1:0]   skid_sum_q;
	logic [CNT_W-1:0]   skid_cnt_q;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_limit_q <= WEIGHT_LIMIT_RST;
			event_limit_q  <= EVENT_LIMIT_RST;
			window_limit_q <= WINDOW_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WEIGHT_LIMIT: weight_limit_q <= cfg_data;
				REG_EVENT_LIMIT:  event_limit_q  <= cfg_data[TOTAL_W-1:0];
				REG_WINDOW_LIMIT: window_limit_q <= cfg_data[WLIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: input stalls only when the skid entry is occupied
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign pop      = out_valid_q && !out_stall;

	// Gap, weight, saturating sum and total for this tick
	assign gap_inc = (gap_q >= GAP_CAP) ? GAP_CAP : gap_q + GAP_W'(1);
	assign gap_n   = overcurrent_event ? '0 : gap_inc;
	assign weight  = overcurrent_event ? weight_of_gap(gap_inc) : '0;
	assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(weight);
	assign sum_n   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
	assign total_n = (overcurrent_event && (total_q != '1)) ? total_q + TOTAL_W'(1) : total_q;

	assign weight_fault = (sum_n > weight_limit_q) || (total_n >= event_limit_q);

	// Advance the window only on accepted ticks without a weight fault
	assign win_ctl.adv = accept && !weight_fault;
	assign win_ctl.ev  = overcurrent_event;

	ofm_window #(
		.WINDOW_LEN (WINDOW_LEN),
		.CNT_W      (CNT_W)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (win_ctl),
		.cnt     (cnt),
		.cnt_nxt (cnt_nxt)
	);

	// Result of this tick
	always_comb begin
		if (weight_fault) begin
			res_fault = FAULT_WEIGHT;
			res_cnt   = cnt;
		end else begin
			res_cnt   = cnt_nxt;
			res_fault = (CMP_W'(cnt_nxt) > CMP_W'(window_limit_q)) ? FAULT_BURST : FAULT_NONE;
		end
	end

	// Tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q   <= '0;
			sum_q   <= '0;
			total_q <= '0;
		end else if (accept) begin
			gap_q   <= gap_n;
			sum_q   <= sum_n;
			total_q <= total_n;
		end
	end

	// Output buffer: main entry faces the port, skid entry catches a stalled result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= accept;
				end
			end else if (accept) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	// Payload of the buffer entries
	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_fault_q <= skid_fault_q;
			out_sum_q   <= skid_sum_q;
			out_cnt_q   <= skid_cnt_q;
		end else if (accept && (pop || !out_valid_q)) begin
			out_fault_q <= res_fault;
			out_sum_q   <= sum_n;
			out_cnt_q   <= res_cnt;
		end
		if (accept && out_valid_q && !pop) begin
			skid_fault_q <= res_fault;
			skid_sum_q   <= sum_n;
			skid_cnt_q   <= res_cnt;
		end
	end

	assign out_valid        = out_valid_q;
	assign fault            = out_fault_q;
	assign weighted_total   = out_sum_q;
	assign events_in_window = out_cnt_q;

	// Skid entry is only used behind a full main entry
	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry occupied with main entry empty");

	a_stalled_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && out_valid_q && out_stall) |=> skid_valid_q)
		else $error("result lost behind stalled output");

	a_gap_capped: assert property (@(posedge clk) disable iff (!arst_n)
		gap_q <= GAP_CAP)
		else $error("gap counter above cap");

	a_sum_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> sum_q >= $past(sum_q))
		else $error("weighted sum decreased");

endmodule
